/* rtl/rpc_pkg.sv */
// package for the radix palindrome check unit: microcode format, step codes and program rom
`default_nettype none

package rpc_pkg;

  // widths fixed by the item format
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned BASE_W          = 31;
  localparam int unsigned STEP_W          = 3;

  // datapath operations
  localparam logic [2:0] OP_NOP     = 3'd0;
  localparam logic [2:0] OP_LOAD    = 3'd1;
  localparam logic [2:0] OP_DIVINIT = 3'd2;
  localparam logic [2:0] OP_DIVSTEP = 3'd3;
  localparam logic [2:0] OP_MUL     = 3'd4;
  localparam logic [2:0] OP_ACC     = 3'd5;
  localparam logic [2:0] OP_EMIT    = 3'd6;

  // jump conditions
  localparam logic [2:0] C_NEVER    = 3'd0;
  localparam logic [2:0] C_ALWAYS   = 3'd1;
  localparam logic [2:0] C_NO_BEAT  = 3'd2;
  localparam logic [2:0] C_SKIP     = 3'd3;
  localparam logic [2:0] C_DONE     = 3'd4;
  localparam logic [2:0] C_CNT_NZ   = 3'd5;
  localparam logic [2:0] C_OUT_FULL = 3'd6;

  // program steps
  localparam logic [STEP_W-1:0] S_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] S_CHECK = 3'd1;
  localparam logic [STEP_W-1:0] S_DIGIT = 3'd2;
  localparam logic [STEP_W-1:0] S_DIV   = 3'd3;
  localparam logic [STEP_W-1:0] S_MUL   = 3'd4;
  localparam logic [STEP_W-1:0] S_ACC   = 3'd5;
  localparam logic [STEP_W-1:0] S_EMIT  = 3'd6;
  localparam logic [STEP_W-1:0] S_BACK  = 3'd7;

  // one control word
  typedef struct packed {
    logic [2:0]        op;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // program rom: taken jump goes to target, else to the next step
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      S_IDLE:  w = '{op: OP_LOAD,    cond: C_NO_BEAT,  target: S_IDLE};
      S_CHECK: w = '{op: OP_NOP,     cond: C_SKIP,     target: S_EMIT};
      S_DIGIT: w = '{op: OP_DIVINIT, cond: C_DONE,     target: S_EMIT};
      S_DIV:   w = '{op: OP_DIVSTEP, cond: C_CNT_NZ,   target: S_DIV};
      S_MUL:   w = '{op: OP_MUL,     cond: C_NEVER,    target: S_IDLE};
      S_ACC:   w = '{op: OP_ACC,     cond: C_ALWAYS,   target: S_DIGIT};
      S_EMIT:  w = '{op: OP_EMIT,    cond: C_OUT_FULL, target: S_EMIT};
      S_BACK:  w = '{op: OP_NOP,     cond: C_ALWAYS,   target: S_IDLE};
      default: w = '{op: OP_NOP,     cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/radix_palindrome_check_unit.sv */
// top level of the radix palindrome check unit: microcoded digit reversal and compare
//
//   channel   dir   tdata                              tuser
//   s_axis    in    value, base (low bits first)       -
//   m_axis    out   is_palindrome                      bad_base
//
// an item with a bad base, a negative value or zero goes straight to the emit step; else
// the digit loop runs once per base digit of value, until the rest is zero or the
// reversed value passes the magnitude (at most all digits); the bit-serial divider
// inside each pass yields one quotient bit a cycle.
// reset clears the step counter and the output valid; no clearing pass is needed.
// a new beat is taken at step zero while an earlier result may still wait in the
// output register; the emit step stalls only when that register is still full.
`default_nettype none

module radix_palindrome_check_unit #(
  parameter int unsigned VALUE_WIDTH = rpc_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // s_axis_tdata_i: value [VALUE_WIDTH-1:0], base [VALUE_WIDTH+30:VALUE_WIDTH], zero pad
  input  wire logic                                             s_axis_tvalid_i,
  output logic                                                  s_axis_tready_o,
  input  wire logic [((VALUE_WIDTH+rpc_pkg::BASE_W+7)/8)*8-1:0] s_axis_tdata_i,
  // m_axis_tdata_o: is_palindrome [0], zero pad
  output logic       m_axis_tvalid_o,
  input  wire logic  m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,
  // m_axis_tuser_o: bad_base [0]
  output logic       m_axis_tuser_o
);
  import rpc_pkg::*;

  localparam int unsigned MAG_W  = VALUE_WIDTH - 1;
  localparam int unsigned PROD_W = MAG_W + BASE_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned CNT_W  = $clog2(VALUE_WIDTH);
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(MAG_W - 1);

  // control
  logic [STEP_W-1:0] upc_q, upc_d;
  ucode_t            uw;
  logic              take_jump;

  // datapath registers
  logic [MAG_W-1:0]  mag_q;
  logic [MAG_W-1:0]  rest_q;
  logic [MAG_W-1:0]  dq_q;
  logic [BASE_W-1:0] rm_q;
  logic [BASE_W-1:0] base_q;
  logic [MAG_W-1:0]  acc_q;
  logic [PROD_W-1:0] prod_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              neg_q, bad_q, fail_q;

  // output register
  logic out_valid_q, out_pal_q, out_bad_q;

  // combinational datapath pieces
  logic [VALUE_WIDTH-1:0] in_value;
  logic [BASE_W-1:0]      in_base;
  logic                   in_beat;
  logic                   out_full;
  logic [BASE_W:0]        trial;
  logic [BASE_W:0]        trial_diff;
  logic                   qbit;
  logic [PROD_W-1:0]      prod_d;
  logic [SUM_W-1:0]       sum;
  logic                   sum_over;
  logic                   pal_now;

  assign uw        = ucode_rom(upc_q);
  assign in_value  = s_axis_tdata_i[VALUE_WIDTH-1:0];
  assign in_base   = s_axis_tdata_i[VALUE_WIDTH+BASE_W-1:VALUE_WIDTH];
  assign s_axis_tready_o = (upc_q == S_IDLE);
  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_full  = out_valid_q && !m_axis_tready_i;

  // restoring division step, one quotient bit
  assign trial      = {rm_q, dq_q[MAG_W-1]};
  assign trial_diff = trial - {1'b0, base_q};
  assign qbit       = (trial >= {1'b0, base_q});

  // multiply of reversed value by base, registered before the add
  assign prod_d   = acc_q * base_q;
  assign sum      = {1'b0, prod_q} + SUM_W'(rm_q);
  assign sum_over = (sum > SUM_W'(mag_q));
  assign pal_now  = !bad_q && !neg_q && !fail_q && (acc_q == mag_q);

  // jump condition select
  always_comb begin
    case (uw.cond)
      C_NEVER:    take_jump = 1'b0;
      C_ALWAYS:   take_jump = 1'b1;
      C_NO_BEAT:  take_jump = !s_axis_tvalid_i;
      C_SKIP:     take_jump = bad_q || neg_q;
      C_DONE:     take_jump = (rest_q == '0) || fail_q;
      C_CNT_NZ:   take_jump = (cnt_q != '0);
      C_OUT_FULL: take_jump = out_full;
      default:    take_jump = 1'b1;
    endcase
    upc_d = take_jump ? uw.target : upc_q + STEP_W'(1);
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  // datapath, driven by the op field
  always_ff @(posedge clk_i) begin
    case (uw.op)
      OP_LOAD: begin
        if (in_beat) begin
          mag_q  <= in_value[MAG_W-1:0];
          rest_q <= in_value[MAG_W-1:0];
          neg_q  <= in_value[VALUE_WIDTH-1];
          base_q <= in_base;
          bad_q  <= (in_base < BASE_W'(2));
          acc_q  <= '0;
          fail_q <= 1'b0;
        end
      end
      OP_DIVINIT: begin
        dq_q  <= rest_q;
        rm_q  <= '0;
        cnt_q <= CNT_INIT;
      end
      OP_DIVSTEP: begin
        rm_q  <= qbit ? trial_diff[BASE_W-1:0] : trial[BASE_W-1:0];
        dq_q  <= {dq_q[MAG_W-2:0], qbit};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      OP_MUL: begin
        prod_q <= prod_d;
      end
      OP_ACC: begin
        acc_q  <= sum[MAG_W-1:0];
        fail_q <= fail_q || sum_over;
        rest_q <= dq_q;
      end
      default: begin
      end
    endcase
  end

  // output register, parted from the input side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uw.op == OP_EMIT && !out_full) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.op == OP_EMIT && !out_full) begin
      out_pal_q <= pal_now;
      out_bad_q <= bad_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_pal_q};
  assign m_axis_tuser_o  = out_bad_q;

  // a bad base never reports a palindrome
  a_bad_not_pal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_pal_q && out_bad_q))
    else $error("bad base reported as palindrome");

  // reversed value never passes the magnitude unless flagged
  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == S_DIGIT && !fail_q) |-> (acc_q <= mag_q))
    else $error("reversed value above magnitude without fail flag");

  // the emit step only leaves once the result is loaded
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == S_EMIT && upc_d == S_BACK) |=> out_valid_q)
    else $error("emit step left without a result");

  // digit loop is only entered with a good base and a non-negative value
  a_loop_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == S_DIV) |-> (!bad_q && !neg_q))
    else $error("division running on a skipped item");

endmodule

`default_nettype wire

/* tb/palindrome_verdict_checker.sv */
// result checker for the radix palindrome check unit: predicts each verdict and compares
`timescale 1ns / 100ps

module palindrome_verdict_checker #(
  parameter int unsigned VALUE_WIDTH = rpc_pkg::VALUE_WIDTH_DEF,
  localparam int unsigned TDATA_W = ((VALUE_WIDTH + rpc_pkg::BASE_W + 7) / 8) * 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // s_axis_tdata_i: value, base, zero pad
  input  wire logic               s_axis_tvalid_i,
  input  wire logic               s_axis_tready_i,
  input  wire logic [TDATA_W-1:0] s_axis_tdata_i,
  // m_axis_tdata_i: is_palindrome, zero pad
  input  wire logic               m_axis_tvalid_i,
  input  wire logic               m_axis_tready_i,
  input  wire logic [7:0]         m_axis_tdata_i,
  // m_axis_tuser_i: bad_base
  input  wire logic               m_axis_tuser_i,
  output int unsigned             mismatch_cnt_o,
  output int unsigned             pending_cnt_o,
  output int unsigned             results_cnt_o,
  output int unsigned             palindromes_cnt_o,
  output int unsigned             bad_base_cnt_o
);

  typedef struct packed {
    logic is_palindrome;
    logic bad_base;
  } verdict_t;

  verdict_t    verdict_q[$];
  int unsigned mismatches;
  int unsigned results;
  int unsigned palindromes;
  int unsigned bad_bases;

  // reverse the digits of a non-negative value and compare with the original
  function automatic verdict_t predict_verdict(input logic [VALUE_WIDTH-1:0] value,
                                               input logic [rpc_pkg::BASE_W-1:0] radix);
    verdict_t    res;
    logic [63:0] rest;
    logic [63:0] mirrored;
    logic [63:0] rdx;
    res      = '{is_palindrome: 1'b0, bad_base: 1'b0};
    rdx      = 64'(radix);
    rest     = 64'(value);
    mirrored = '0;
    if (rdx < 64'd2) begin
      res.bad_base = 1'b1;
    end else if (!value[VALUE_WIDTH-1]) begin
      while (rest != 64'd0) begin
        mirrored = mirrored * rdx + rest % rdx;
        rest     = rest / rdx;
      end
      res.is_palindrome = (mirrored == 64'(value));
    end
    return res;
  endfunction

  // results are compared before new beats are queued, so a result never meets
  // the prediction of the beat taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      verdict_q.delete();
      mismatches = 0;
      results    = 0;
      palindromes = 0;
      bad_bases  = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        results++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          $error("result beat with no input beat waiting (is_palindrome %0b, bad_base %0b)",
                 m_axis_tdata_i[0], m_axis_tuser_i);
        end else begin
          want = verdict_q.pop_front();
          if (want.is_palindrome) palindromes++;
          if (want.bad_base) bad_bases++;
          if (m_axis_tdata_i[0] !== want.is_palindrome) begin
            mismatches++;
            $error("is_palindrome mismatch: expected %0b, actual %0b",
                   want.is_palindrome, m_axis_tdata_i[0]);
          end
          if (m_axis_tuser_i !== want.bad_base) begin
            mismatches++;
            $error("bad_base mismatch: expected %0b, actual %0b",
                   want.bad_base, m_axis_tuser_i);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        verdict_q.push_back(predict_verdict(
          s_axis_tdata_i[VALUE_WIDTH-1:0],
          s_axis_tdata_i[VALUE_WIDTH+rpc_pkg::BASE_W-1:VALUE_WIDTH]));
      end
    end
    mismatch_cnt_o    <= mismatches;
    pending_cnt_o     <= verdict_q.size();
    results_cnt_o     <= results;
    palindromes_cnt_o <= palindromes;
    bad_base_cnt_o    <= bad_bases;
  end

endmodule

/* tb/tb_radix_palindrome_check_unit.sv */
// testbench top for the radix palindrome check unit: stimulus, stall patterns and verdict
`timescale 1ns / 100ps

module tb_radix_palindrome_check_unit;

  localparam int unsigned VALUE_WIDTH  = rpc_pkg::VALUE_WIDTH_DEF;
  localparam int unsigned BASE_W       = rpc_pkg::BASE_W;
  localparam int unsigned TDATA_W      = ((VALUE_WIDTH + BASE_W + 7) / 8) * 8;
  localparam int unsigned RANDOM_ITEMS = 430;
  localparam int unsigned DRAIN_CYCLES = 1200;
  localparam int unsigned IDLE_LIMIT   = 20000;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_CHOPPY,
    RX_LULL
  } rx_mode_e;

  logic               clk;
  logic               rst_n         = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [7:0]         m_axis_tdata;
  logic               m_axis_tuser;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned results_cnt;
  int unsigned palindromes_cnt;
  int unsigned bad_base_cnt;

  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  rx_mode_e    rx_mode     = RX_OPEN;
  logic [8:0]  rx_phase    = '0;
  int unsigned rx_hold     = 0;

  radix_palindrome_check_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  palindrome_verdict_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid_i  (s_axis_tvalid),
    .s_axis_tready_i  (s_axis_tready),
    .s_axis_tdata_i   (s_axis_tdata),
    .m_axis_tvalid_i  (m_axis_tvalid),
    .m_axis_tready_i  (m_axis_tready),
    .m_axis_tdata_i   (m_axis_tdata),
    .m_axis_tuser_i   (m_axis_tuser),
    .mismatch_cnt_o   (mismatch_cnt),
    .pending_cnt_o    (pending_cnt),
    .results_cnt_o    (results_cnt),
    .palindromes_cnt_o(palindromes_cnt),
    .bad_base_cnt_o   (bad_base_cnt)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: open, choppy and long-lull phases, the mode picked anew whenever rx_phase wraps
  always @(posedge clk) begin
    rx_phase <= rx_phase + 9'd1;
    if (rx_phase == 9'd511) rx_mode <= rx_mode_e'($urandom_range(2, 0));
    if (rx_hold != 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: begin
          m_axis_tready <= 1'b1;
        end
        RX_CHOPPY: begin
          m_axis_tready <= ($urandom_range(3, 0) != 0);
        end
        default: begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(63, 0) == 0) rx_hold <= $urandom_range(300, 20);
        end
      endcase
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("radix_palindrome_check_unit verification failed");
        $finish;
      end
    end
  end

  // one input beat; bursts of random length, random gaps between them
  task automatic send_item(input logic [VALUE_WIDTH-1:0] value, input logic [BASE_W-1:0] radix);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom};
      repeat ($urandom_range(20, 1)) @(posedge clk);
      burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'({radix, value});
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    items_sent++;
  endtask

  // radix spread from tiny to the largest 31-bit value
  function automatic logic [BASE_W-1:0] pick_radix();
    case ($urandom_range(9, 0))
      0, 1, 2, 3: return BASE_W'($urandom_range(10, 2));
      4, 5, 6:    return BASE_W'($urandom_range(300, 11));
      7, 8:       return BASE_W'($urandom_range(65536, 301));
      default:    return BASE_W'($urandom_range(32'h7fff_ffff, 65537));
    endcase
  endfunction

  // mirrored digit string in radix; fewer digits until it fits a positive value
  function automatic logic [VALUE_WIDTH-1:0] build_mirror(input logic [BASE_W-1:0] radix,
                                                           input int unsigned ndigits);
    logic [31:0] half_digits[32];
    logic [63:0] acc;
    int unsigned n;
    int unsigned half;
    logic        fits;
    n    = ndigits;
    acc  = '0;
    fits = 1'b0;
    while (!fits) begin
      half = (n + 1) / 2;
      half_digits[0] = $urandom_range(32'(radix) - 1, 1);
      for (int i = 1; i < half; i++) half_digits[i] = $urandom_range(32'(radix) - 1, 0);
      acc  = '0;
      fits = 1'b1;
      for (int i = 0; i < n; i++) begin
        acc = acc * 64'(radix) + 64'((i < half) ? half_digits[i] : half_digits[n-1-i]);
        if (acc > 64'h7fff_ffff) fits = 1'b0;
        if (!fits) break;
      end
      if (!fits) n--;
    end
    return VALUE_WIDTH'(acc);
  endfunction

  initial begin
    logic [BASE_W-1:0]      radix;
    logic [VALUE_WIDTH-1:0] value;
    int unsigned            sel;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: zero, bad bases, negatives, extremes, known palindromes
    send_item(32'd0, 31'd2);
    send_item(32'd0, 31'd0);
    send_item(32'd0, 31'd1);
    send_item(32'hffff_ffff, 31'd0);
    send_item(32'h7fff_ffff, 31'd1);
    send_item(32'hffff_ffff, 31'd10);
    send_item(32'h8000_0000, 31'd2);
    send_item(32'h7fff_ffff, 31'd2);
    send_item(32'h7fff_ffff, 31'h7fff_ffff);
    send_item(32'h7fff_fffe, 31'h7fff_ffff);
    send_item(32'h7fff_ffff, 31'd10);
    send_item(32'd1234554321, 31'd10);
    send_item(32'd12321, 31'd10);
    send_item(32'd12345, 31'd10);
    send_item(32'd585, 31'd2);
    send_item(32'd1, 31'd2);
    send_item(32'd2, 31'd2);
    send_item(32'd3, 31'd2);
    send_item(32'd255, 31'd16);
    send_item(32'd256, 31'd16);
    send_item(32'h4000_0001, 31'h4000_0000);
    send_item(32'h7fff_fffe, 31'h4000_0000);

    // random: mirrored digit strings as the largest share, some near misses, noise and corner kinds
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      radix = pick_radix();
      sel   = $urandom_range(19, 0);
      if (sel < 9) begin
        value = build_mirror(radix, $urandom_range(31, 1));
      end else if (sel < 12) begin
        value = build_mirror(radix, $urandom_range(31, 1)) ^ (32'd1 << $urandom_range(4, 0));
      end else if (sel < 16) begin
        value = $urandom;
      end else if (sel < 18) begin
        value = $urandom | 32'h8000_0000;
      end else if (sel == 18) begin
        value = $urandom;
        radix = BASE_W'($urandom_range(1, 0));
      end else begin
        value = '0;
      end
      send_item(value, radix);
    end

    s_axis_tvalid <= 1'b0;
    while (results_cnt < items_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input beats: %0d palindromes, %0d bad-base results, the rest not",
             items_sent, palindromes_cnt, bad_base_cnt);
    $display("mismatches %0d, results still outstanding %0d", mismatch_cnt, pending_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("radix_palindrome_check_unit verification clean");
    end else begin
      $display("radix_palindrome_check_unit verification failed");
    end
    $finish;
  end

endmodule
